### rtl/hcbd_pkg.sv
package hcbd_pkg;

   localparam int unsigned ByteWidth = 8;
   localparam int unsigned DigitWidth = 4;

   localparam logic [ByteWidth-1:0] CharSemi = 8'h3B;
   localparam logic [ByteWidth-1:0] CharCr = 8'h0D;
   localparam logic [ByteWidth-1:0] CharLf = 8'h0A;
   localparam logic [ByteWidth-1:0] CharZero = 8'h30;
   localparam logic [ByteWidth-1:0] CharNine = 8'h39;
   localparam logic [ByteWidth-1:0] CharLowA = 8'h61;
   localparam logic [ByteWidth-1:0] CharLowF = 8'h66;
   localparam logic [ByteWidth-1:0] CharUpA = 8'h41;
   localparam logic [ByteWidth-1:0] CharUpF = 8'h46;
   localparam logic [DigitWidth-1:0] HexTen = 4'd10;

   typedef enum logic [6:0] {
      PH_SIZE = 7'b0000001,
      PH_EXT  = 7'b0000010,
      PH_LF1  = 7'b0000100,
      PH_DATA = 7'b0001000,
      PH_CR   = 7'b0010000,
      PH_LF2  = 7'b0100000,
      PH_END  = 7'b1000000
   } phase_type;

   typedef struct packed {
      logic                 payload_valid;
      logic [ByteWidth-1:0] payload_byte;
      logic                 body_done;
   } result_type;

   typedef struct packed {
      logic                  is_hex;
      logic [DigitWidth-1:0] value;
   } hex_type;

   function automatic hex_type hex_decode(input logic [ByteWidth-1:0] b);
      hex_type h;
      logic [ByteWidth-1:0] diff;
      h = '{is_hex: 1'b0, value: '0};
      diff = '0;
      if (b >= CharZero && b <= CharNine) begin
         diff = b - CharZero;
         h = '{is_hex: 1'b1, value: diff[DigitWidth-1:0]};
      end else if (b >= CharLowA && b <= CharLowF) begin
         diff = b - CharLowA;
         h = '{is_hex: 1'b1, value: diff[DigitWidth-1:0] + HexTen};
      end else if (b >= CharUpA && b <= CharUpF) begin
         diff = b - CharUpA;
         h = '{is_hex: 1'b1, value: diff[DigitWidth-1:0] + HexTen};
      end
      return h;
   endfunction

endpackage

### rtl/hcbd_step.sv
module hcbd_step import hcbd_pkg::*; #(
   parameter int unsigned SIZE_WIDTH = 32
) (
   input  phase_type             phase,
   input  logic [SIZE_WIDTH-1:0] count,
   input  logic [ByteWidth-1:0]  data_byte,
   output phase_type             phase_in,
   output logic [SIZE_WIDTH-1:0] count_in,
   output result_type            result
);

   hex_type               hex;
   logic [SIZE_WIDTH-1:0] count_dec;
   phase_type             line_end;
   logic                  valid;

   assign hex = hex_decode(data_byte);
   assign count_dec = count - {{(SIZE_WIDTH-1){1'b0}}, 1'b1};
   assign line_end = (count != '0) ? PH_DATA : PH_END;

   always_comb begin
      phase_in = phase;
      count_in = count;
      valid = 1'b0;
      unique case (phase)
         PH_SIZE: begin
            if (hex.is_hex) begin
               count_in = {count[SIZE_WIDTH-DigitWidth-1:0], hex.value};
            end else if (data_byte == CharSemi) begin
               phase_in = PH_EXT;
            end else if (data_byte == CharCr) begin
               phase_in = PH_LF1;
            end else if (data_byte == CharLf) begin
               phase_in = line_end;
            end
         end
         PH_EXT: begin
            if (data_byte == CharCr) begin
               phase_in = PH_LF1;
            end else if (data_byte == CharLf) begin
               phase_in = line_end;
            end
         end
         PH_LF1: begin
            if (data_byte == CharLf) begin
               phase_in = line_end;
            end
         end
         PH_DATA: begin
            valid = 1'b1;
            count_in = count_dec;
            if (count_dec == '0) begin
               phase_in = PH_CR;
            end
         end
         PH_CR: begin
            if (data_byte == CharCr) begin
               phase_in = PH_LF2;
            end else if (data_byte == CharLf) begin
               phase_in = PH_SIZE;
               count_in = '0;
            end
         end
         PH_LF2: begin
            phase_in = PH_SIZE;
            count_in = '0;
         end
         default: begin
            phase_in = PH_END;
         end
      endcase
   end

   assign result.payload_valid = valid;
   assign result.payload_byte = valid ? data_byte : '0;
   assign result.body_done = (phase_in == PH_END);

endmodule

### rtl/http_chunked_body_decoder.sv
// Decodes an HTTP chunked-transfer body one byte per beat and flags which bytes are
// chunk payload. Each accepted req beat yields exactly one rsp beat, in order. The
// block takes a new beat every cycle while the rsp side is not stalled; a beat passes
// through the input register and then the result register, and the parser state is
// updated as the beat moves from the input register to the result register. A stalled
// rsp side holds the whole two-stage pipe. Chunk sizes are SIZE_WIDTH bits and wrap on
// overflow; a zero-size chunk sets body_done for good, and only reset leaves that
// state.
module http_chunked_body_decoder import hcbd_pkg::*; #(
   parameter int unsigned SIZE_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,  // data_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,  // payload_byte
   output logic [1:0]  rsp_tuser   // body_done, payload_valid
);

   logic                  advance;
   logic                  in_valid_ff;
   logic [ByteWidth-1:0]  in_byte_ff;
   phase_type             phase_ff;
   phase_type             phase_in;
   logic [SIZE_WIDTH-1:0] count_ff;
   logic [SIZE_WIDTH-1:0] count_in;
   result_type            result_in;
   result_type            result_ff;
   logic                  rsp_valid_ff;

   assign advance = !rsp_valid_ff || rsp_tready;
   assign req_tready = advance;

   hcbd_step #(
      .SIZE_WIDTH(SIZE_WIDTH)
   ) u_step (
      .phase    (phase_ff),
      .count    (count_ff),
      .data_byte(in_byte_ff),
      .phase_in (phase_in),
      .count_in (count_in),
      .result   (result_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         phase_ff <= PH_SIZE;
         count_ff <= '0;
      end else if (advance) begin
         in_valid_ff <= req_tvalid;
         rsp_valid_ff <= in_valid_ff;
         if (in_valid_ff) begin
            phase_ff <= phase_in;
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         in_byte_ff <= req_tdata;
         if (in_valid_ff) begin
            result_ff <= result_in;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = result_ff.payload_byte;
   assign rsp_tuser = {result_ff.body_done, result_ff.payload_valid};

endmodule
